/* sv/coalescing_control_event_queue_defines.svh */
// Assertion macros for the coalescing control event queue.
`ifndef COALESCING_CONTROL_EVENT_QUEUE_DEFINES_SVH
`define COALESCING_CONTROL_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccq check failed");

// Next-cycle implication, disabled during reset.
`define CCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccq check failed");

`endif

/* sv/ccq_pkg.sv */
// Types and constants shared by the coalescing control event queue files.
package ccq_pkg;

  localparam int KNOB_COUNT = 3;
  localparam int SLOT_AW    = $clog2(KNOB_COUNT);
  localparam int VALUE_W    = 12;
  localparam int KIND_W     = 3;
  localparam int OKIND_W    = 2;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [KIND_W-1:0]  KIND_SWITCH  = 3'd3;
  localparam logic [KIND_W-1:0]  KIND_NONE    = 3'd4;
  localparam logic [OKIND_W-1:0] SLOT_SWITCH  = 2'd3;

  typedef struct packed {
    logic               command;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] prev_value;
    logic [VALUE_W-1:0] now_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [OKIND_W-1:0] out_kind;
    logic [VALUE_W-1:0] out_prev;
    logic [VALUE_W-1:0] out_now;
    logic               pending;
  } out_item_t;

  typedef struct packed {
    logic [OKIND_W-1:0] kind;
    logic [VALUE_W-1:0] prev;
    logic [VALUE_W-1:0] now;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

endpackage

/* sv/ccq_req_if.sv */
// Request channel of the coalescing control event queue.
interface ccq_req_if import ccq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/ccq_rsp_if.sv */
// Result channel of the coalescing control event queue.
interface ccq_rsp_if import ccq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/coalescing_control_event_queue.sv */
// Coalescing control event queue: three knob slots held in a small synchronous memory.
//
// req_ch carries one request: command (add or pop), kind, prev_value, now_value.
// rsp_ch returns exactly one result per request: found, out_kind, out_prev,
// out_now and pending. Both are valid/ready channels; a transfer happens on a
// clock edge with valid and ready high.
// One request is worked on at a time. After acceptance the request is decided
// in ST_EXEC (slot valid bits and the switch flag are in flip-flops), and a
// refresh of a filled knob slot or a pop that finds an event then waits in
// ST_WAIT for the registered slot memory read. The result register loads at
// the end of that, and req_ch.ready returns in the cycle the result loads.
// If the receiver stalls, the result is held in the output register, the next
// request is still taken, and it waits before its final step until the held
// result drains.
// rst (synchronous) empties all slots, clears pending and the scan start.
// The slot memory needs no clearing pass: its contents are read only for
// slots whose valid bit is set.
`include "coalescing_control_event_queue_defines.svh"

module coalescing_control_event_queue import ccq_pkg::*; (
  input  logic clk,
  input  logic rst,
  ccq_req_if.sink   req_ch,
  ccq_rsp_if.source rsp_ch
);

  state_t                 state, state_next;
  in_item_t               req_q;
  logic [KNOB_COUNT-1:0]  valid_bits, valid_bits_next;
  logic                   sw0, sw0_next;
  logic [SLOT_AW-1:0]     scan_start, scan_start_next;
  logic                   pending_flag, pending_flag_next;
  logic                   out_valid, out_valid_next;
  out_item_t              out_q, out_q_next;

  slot_t                  mem [KNOB_COUNT];
  slot_t                  rd_data, wr_data;
  logic                   rd_en, wr_en;
  logic [SLOT_AW-1:0]     rd_addr, wr_addr;

  logic                   out_free, is_switch, is_knob, refresh;
  logic [SLOT_AW-1:0]     knob_idx, idx0, idx1, idx2, pop_idx;
  logic                   pop_hit;

  function automatic logic [SLOT_AW-1:0] slot_inc(input logic [SLOT_AW-1:0] s);
    return (s == SLOT_AW'(KNOB_COUNT - 1)) ? '0 : s + SLOT_AW'(1);
  endfunction

  assign req_ch.ready = (state == ST_IDLE);
  assign rsp_ch.valid = out_valid;
  assign rsp_ch.data  = out_q;

  assign out_free  = !out_valid || rsp_ch.ready;
  assign is_switch = (req_q.kind == KIND_SWITCH);
  assign is_knob   = (req_q.kind < KIND_W'(KNOB_COUNT));
  assign knob_idx  = req_q.kind[SLOT_AW-1:0];
  assign refresh   = is_knob && !sw0 && valid_bits[knob_idx];

  // Round-robin pick from the scan start.
  assign idx0 = scan_start;
  assign idx1 = slot_inc(idx0);
  assign idx2 = slot_inc(idx1);
  assign pop_hit = |valid_bits;
  always_comb begin
    if (valid_bits[idx0]) begin
      pop_idx = idx0;
    end else if (valid_bits[idx1]) begin
      pop_idx = idx1;
    end else begin
      pop_idx = idx2;
    end
  end

  always_comb begin
    state_next        = state;
    valid_bits_next   = valid_bits;
    sw0_next          = sw0;
    scan_start_next   = scan_start;
    pending_flag_next = pending_flag;
    out_valid_next    = out_valid && !rsp_ch.ready;
    out_q_next        = out_q;
    rd_en             = 1'b0;
    rd_addr           = knob_idx;
    wr_en             = 1'b0;
    wr_addr           = knob_idx;
    wr_data           = '{kind: req_q.kind[OKIND_W-1:0], prev: req_q.prev_value,
                          now: req_q.now_value};

    case (state)
      ST_IDLE: begin
        if (req_ch.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_q.command == CMD_ADD && refresh) begin
          // Keep the first earlier reading: fetch the slot before rewriting it.
          rd_en      = 1'b1;
          rd_addr    = knob_idx;
          state_next = ST_WAIT;
        end else if (req_q.command == CMD_POP && pop_hit) begin
          rd_en                    = 1'b1;
          rd_addr                  = pop_idx;
          valid_bits_next[pop_idx] = 1'b0;
          if (pop_idx == '0) begin
            sw0_next = 1'b0;
          end
          pending_flag_next = ($countones(valid_bits) > 1);
          scan_start_next   = slot_inc(scan_start);
          state_next        = ST_WAIT;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_q_next     = '0;
          if (req_q.command == CMD_POP) begin
            pending_flag_next = 1'b0;
            scan_start_next   = slot_inc(scan_start);
          end else begin
            pending_flag_next  = 1'b1;
            out_q_next.pending = 1'b1;
            if (is_switch) begin
              wr_en           = 1'b1;
              wr_addr         = '0;
              valid_bits_next = KNOB_COUNT'(1);
              sw0_next        = 1'b1;
            end else if (is_knob && !sw0) begin
              wr_en                     = 1'b1;
              wr_addr                   = knob_idx;
              valid_bits_next[knob_idx] = 1'b1;
            end
          end
          state_next = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (req_q.command == CMD_ADD) begin
            wr_en              = 1'b1;
            wr_addr            = knob_idx;
            wr_data            = '{kind: rd_data.kind, prev: rd_data.prev,
                                   now: req_q.now_value};
            pending_flag_next  = 1'b1;
            out_q_next         = '0;
            out_q_next.pending = 1'b1;
          end else begin
            out_q_next = '{found: 1'b1, out_kind: rd_data.kind, out_prev: rd_data.prev,
                           out_now: rd_data.now, pending: pending_flag};
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid_bits   <= '0;
      sw0          <= 1'b0;
      scan_start   <= '0;
      pending_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      valid_bits   <= valid_bits_next;
      sw0          <= sw0_next;
      scan_start   <= scan_start_next;
      pending_flag <= pending_flag_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_q <= out_q_next;
    if (req_ch.valid && req_ch.ready) begin
      req_q <= req_ch.data;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  `CCQ_ASSERT_IMPL(a_switch_in_slot0, clk, rst, sw0, valid_bits[0])
  `CCQ_ASSERT_IMPL(a_switch_clears_knobs, clk, rst, sw0, valid_bits[KNOB_COUNT-1:1] == '0)
  `CCQ_ASSERT_IMPL(a_stored_means_pending, clk, rst, |valid_bits, pending_flag)
  `CCQ_ASSERT_NEXT(a_one_request_at_a_time, clk, rst, req_ch.valid && req_ch.ready,
                   !req_ch.ready)

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the coalescing control event queue.
module tb;
  import ccq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_WAIT  = 10;

  // Tracks the three knob slots and the scan start, and holds the results due.
  class slot_tracker;
    bit          full [KNOB_COUNT];
    slot_t       slot [KNOB_COUNT];
    int unsigned scan_start;
    bit          pending;
    out_item_t   results_due[$];
    int          errors;

    function new();
      for (int i = 0; i < KNOB_COUNT; i++) begin
        full[i] = 1'b0;
        slot[i] = '0;
      end
      scan_start = 0;
      pending = 1'b0;
      errors = 0;
    endfunction

    function out_item_t apply_request(in_item_t r);
      out_item_t   res;
      int unsigned idx;
      bit          remain;
      res = '0;
      remain = 1'b0;
      if (r.command == CMD_ADD) begin
        pending = 1'b1;
        if (r.kind == KIND_SWITCH) begin
          full[0] = 1'b1;
          slot[0] = '{kind: SLOT_SWITCH, prev: r.prev_value, now: r.now_value};
          for (int i = 1; i < KNOB_COUNT; i++) begin
            full[i] = 1'b0;
            slot[i] = '0;
          end
        end else if (r.kind < KNOB_COUNT && !(full[0] && slot[0].kind == SLOT_SWITCH)) begin
          idx = 32'(r.kind);
          if (!full[idx]) begin
            full[idx] = 1'b1;
            slot[idx] = '{kind: r.kind[OKIND_W-1:0], prev: r.prev_value, now: r.now_value};
          end else begin
            // keep the first earlier reading, refresh the current one
            slot[idx].now = r.now_value;
          end
        end
      end else begin
        for (int i = 0; i < KNOB_COUNT; i++) begin
          idx = (scan_start + i) % KNOB_COUNT;
          if (full[idx]) begin
            if (!res.found) begin
              res.found = 1'b1;
              res.out_kind = slot[idx].kind;
              res.out_prev = slot[idx].prev;
              res.out_now = slot[idx].now;
              full[idx] = 1'b0;
              slot[idx] = '0;
            end else begin
              remain = 1'b1;
            end
          end
        end
        pending = remain;
        scan_start = (scan_start + 1) % KNOB_COUNT;
      end
      res.pending = pending;
      return res;
    endfunction

    function void note_request(in_item_t r);
      results_due.push_back(apply_request(r));
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare("found", want.found, got.found);
      compare("out_kind", want.out_kind, got.out_kind);
      compare("out_prev", want.out_prev, got.out_prev);
      compare("out_now", want.out_now, got.out_now);
      compare("pending", want.pending, got.pending);
    endfunction
  endclass

  logic clk;
  logic rst;

  ccq_req_if req_ch ();
  ccq_rsp_if rsp_ch ();

  coalescing_control_event_queue dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  slot_tracker tracker = new();

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;
  int cycle_count;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_result(rsp_ch.data);
    end
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic in_item_t make_req(logic cmd, logic [KIND_W-1:0] kind,
                                        logic [VALUE_W-1:0] prev, logic [VALUE_W-1:0] now);
    in_item_t r;
    r.command = cmd;
    r.kind = kind;
    r.prev_value = prev;
    r.now_value = now;
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return '1;
    end
    return VALUE_W'($urandom_range(4095));
  endfunction

  function automatic in_item_t random_req();
    int unsigned sel;
    logic [KIND_W-1:0] kind;
    sel = $urandom_range(99);
    if (sel < 70) begin
      kind = KIND_W'($urandom_range(KNOB_COUNT - 1));
    end else if (sel < 80) begin
      kind = KIND_SWITCH;
    end else if (sel < 90) begin
      kind = KIND_NONE;
    end else begin
      kind = KIND_W'($urandom_range(7, 5));
    end
    return make_req(($urandom_range(99) < 40) ? CMD_POP : CMD_ADD, kind,
                    pick_value(), pick_value());
  endfunction

  // Offer one request, with random idle cycles first; valid stays high after it.
  task automatic send(in_item_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    tracker.note_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.results_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    in_item_t directed[$];
    int tx_pcts[4];
    int rx_pcts[4];

    tx_pcts = '{0, 45, 0, 36};
    rx_pcts = '{0, 0, 45, 36};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;

    directed = '{
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_ADD, 3'd0, 12'h000, 12'hFFF),
      make_req(CMD_ADD, 3'd0, 12'hFFF, 12'h000),
      make_req(CMD_ADD, 3'd1, 12'hFFF, 12'hFFF),
      make_req(CMD_ADD, 3'd2, 12'h555, 12'hAAA),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_POP, 3'd7, 12'hFFF, 12'hFFF),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_ADD, KIND_NONE, 12'h123, 12'h456),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_ADD, 3'd7, 12'hFFF, 12'hFFF),
      make_req(CMD_ADD, 3'd5, 12'h0F0, 12'hF0F),
      make_req(CMD_ADD, 3'd6, 12'hAAA, 12'h555),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_ADD, 3'd1, 12'h123, 12'h456),
      make_req(CMD_ADD, 3'd2, 12'h789, 12'hABC),
      make_req(CMD_ADD, KIND_SWITCH, 12'hABC, 12'hDEF),
      make_req(CMD_ADD, 3'd2, 12'h111, 12'h222),
      make_req(CMD_ADD, 3'd0, 12'h333, 12'h444),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000),
      make_req(CMD_ADD, KIND_SWITCH, 12'h000, 12'h000),
      make_req(CMD_ADD, KIND_SWITCH, 12'hFFF, 12'hFFF),
      make_req(CMD_POP, 3'd0, 12'h000, 12'h000)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send(directed[i]);
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = tx_pcts[p];
      rx_stall_pct <= rx_pcts[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the result side for a long stretch while requests keep coming
        if (p == 0 && n == 10) begin
          hold_left <= LONG_HOLD;
        end
        send(random_req());
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0 && tracker.results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/ccq_pkg.sv
sv/ccq_req_if.sv
sv/ccq_rsp_if.sv
sv/coalescing_control_event_queue.sv
tb/sv/tb.sv
